// ===== design/hpps_pkg.sv =====
// ----------------------------------------------------------------------------
// hpps_pkg: shared types and constants of the haptic pulse pattern sequencer
// Waveform shape table, register indexes, command codes and the control
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hpps_pkg;

  localparam int WAVE_COUNT = 7;
  localparam int WAVE_W     = 3;
  localparam int SCALE_W    = 7;
  localparam int PERIOD_W   = 27;
  localparam int MS_W       = 9;
  localparam int PCNT_W     = 2;
  localparam int PROD_W     = PERIOD_W + SCALE_W;

  localparam logic [SCALE_W-1:0]  SCALE_MAX   = SCALE_W'(100);
  localparam logic [SCALE_W-1:0]  SCALE_RST   = SCALE_W'(100);
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(1000000);

  // Division by one hundred: restoring steps, several quotient bits per cycle
  localparam int                 DIV_BITS    = 8;
  localparam int                 DIV_CYCLES  = (PROD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int                 NUM_W       = DIV_CYCLES * DIV_BITS;
  localparam int                 REM_W       = 7;
  localparam logic [REM_W:0]     DIVISOR     = (REM_W+1)'(100);
  localparam int                 DCNT_W      = $clog2(DIV_CYCLES);

  typedef enum logic [WAVE_W-1:0] {
    WAVE_TAP    = 3'd0,
    WAVE_BEAT   = 3'd1,
    WAVE_WARN   = 3'd2,
    WAVE_BUZZ   = 3'd3,
    WAVE_LONG   = 3'd4,
    WAVE_DOUBLE = 3'd5,
    WAVE_TRIPLE = 3'd6,
    WAVE_NONE   = 3'd7
  } wave_t;

  typedef enum logic {
    CMD_RENDER = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_code_t;

  typedef enum logic {
    REG_AMP_SCALE  = 1'b0,
    REG_PWM_PERIOD = 1'b1
  } reg_idx_t;

  // quarter: base duty is 25 percent instead of 100
  typedef struct packed {
    logic              quarter;
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
    logic [PCNT_W-1:0] count;
  } shape_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic div_last;
    logic load_out;
  } hpps_cmd_t;

  typedef struct packed {
    logic pulse_start;
    logic out_free;
  } hpps_sts_t;

  function automatic shape_t wave_shape(input logic [WAVE_W-1:0] w);
    shape_t s;
    s = '0;
    unique case (w)
      WAVE_TAP:    s = '{1'b0, MS_W'(40),  MS_W'(0),  PCNT_W'(1)};
      WAVE_BEAT:   s = '{1'b1, MS_W'(40),  MS_W'(0),  PCNT_W'(1)};
      WAVE_WARN:   s = '{1'b0, MS_W'(150), MS_W'(0),  PCNT_W'(1)};
      WAVE_BUZZ:   s = '{1'b0, MS_W'(80),  MS_W'(0),  PCNT_W'(1)};
      WAVE_LONG:   s = '{1'b0, MS_W'(400), MS_W'(0),  PCNT_W'(1)};
      WAVE_DOUBLE: s = '{1'b0, MS_W'(40),  MS_W'(60), PCNT_W'(2)};
      WAVE_TRIPLE: s = '{1'b0, MS_W'(40),  MS_W'(60), PCNT_W'(3)};
      default:     s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/hpps_in_if.sv =====
// ----------------------------------------------------------------------------
// hpps_in_if: request channel
// Render requests and millisecond ticks with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpps_in_if import hpps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WAVE_W-1:0] waveform;

  modport source (output valid, output cmd, output waveform, input ready);
  modport sink   (input valid, input cmd, input waveform, output ready);
endinterface

// ===== design/hpps_out_if.sv =====
// ----------------------------------------------------------------------------
// hpps_out_if: result channel
// One status transaction per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpps_out_if import hpps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] pulse_width_ns;
  logic                busy_res;
  logic [WAVE_W-1:0]   playing;
  logic                dropped;

  modport source (output valid, output pulse_width_ns, output busy_res,
                  output playing, output dropped, input ready);
  modport sink   (input valid, input pulse_width_ns, input busy_res,
                  input playing, input dropped, output ready);
endinterface

// ===== design/hpps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hpps_cfg_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpps_cfg_if import hpps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                index;
  logic [PERIOD_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/hpps_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpps_ctrl: sequencing controller
// Accepts a request, runs the multiply and divide steps when a pulse starts,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module hpps_ctrl import hpps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hpps_sts_t sts,
  output hpps_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic               div_end;

  assign div_end = (dcnt_r == DCNT_W'(DIV_CYCLES - 1));

  always_comb begin
    state_nxt    = state_r;
    dcnt_nxt     = dcnt_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = sts.pulse_start ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = div_end;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (div_end) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // After the last divide step the controller moves to the output state
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |=> (state_r == ST_OUT))
    else $error("divide ended without moving to output");

endmodule

// ===== design/hpps_dp.sv =====
// ----------------------------------------------------------------------------
// hpps_dp: sequencer datapath
// Holds configuration, waveform phase state, the pulse width multiply and
// divide unit and the output register.
// ----------------------------------------------------------------------------
module hpps_dp import hpps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_cmd,
  input  logic [WAVE_W-1:0] in_wave,
  input  hpps_cmd_t         cmd,
  output hpps_sts_t         sts,
  hpps_cfg_if.sink          cfg_ch,
  hpps_out_if.source        out_ch
);

  logic [SCALE_W-1:0]  scale_r;
  logic [PERIOD_W-1:0] period_r;
  logic [WAVE_W-1:0]   cur_r, cur_nxt;
  logic [PCNT_W-1:0]   pulses_r, pulses_nxt;
  logic                gap_r, gap_nxt;
  logic [MS_W-1:0]     phase_r, phase_nxt;
  logic [PERIOD_W-1:0] drive_r, drive_nxt;
  logic                dropped_r, dropped_nxt;

  logic [NUM_W-1:0]    num_r;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [PERIOD_W-1:0] quo_r, quo_nxt;

  logic                out_valid_r;
  logic [PERIOD_W-1:0] out_width_r;
  logic [WAVE_W-1:0]   out_play_r;
  logic                out_drop_r;

  shape_t              new_shape, cur_shape;
  logic [SCALE_W-1:0]  duty;
  logic [MS_W-1:0]     ph_dec;
  logic [PCNT_W-1:0]   pulses_dec;
  logic                pulse_start;

  assign new_shape  = wave_shape(in_wave);
  assign cur_shape  = wave_shape(cur_r);
  assign ph_dec     = (phase_r == '0) ? '0 : phase_r - MS_W'(1);
  assign pulses_dec = pulses_r - PCNT_W'(1);
  assign duty       = cur_shape.quarter ? (scale_r >> 2) : scale_r;

  // Request decode and phase stepping
  always_comb begin
    cur_nxt     = cur_r;
    pulses_nxt  = pulses_r;
    gap_nxt     = gap_r;
    phase_nxt   = phase_r;
    drive_nxt   = drive_r;
    dropped_nxt = dropped_r;
    pulse_start = 1'b0;
    if (in_cmd == CMD_RENDER) begin
      dropped_nxt = 1'b1;
      if (in_wave != WAVE_NONE && !(cur_r == WAVE_TAP && in_wave == WAVE_BEAT)) begin
        dropped_nxt = 1'b0;
        cur_nxt     = in_wave;
        pulses_nxt  = new_shape.count;
        gap_nxt     = 1'b0;
        phase_nxt   = new_shape.on_ms;
        pulse_start = 1'b1;
      end
    end else begin
      dropped_nxt = 1'b0;
      if (cur_r != WAVE_NONE) begin
        phase_nxt = ph_dec;
        if (ph_dec == '0) begin
          if (!gap_r) begin
            drive_nxt  = '0;
            pulses_nxt = pulses_dec;
            if (pulses_dec == '0) begin
              cur_nxt   = WAVE_NONE;
              phase_nxt = '0;
            end else begin
              gap_nxt   = 1'b1;
              phase_nxt = cur_shape.off_ms;
            end
          end else begin
            gap_nxt     = 1'b0;
            phase_nxt   = cur_shape.on_ms;
            pulse_start = 1'b1;
          end
        end
      end
    end
  end

  // Eight restoring division steps by one hundred per cycle
  always_comb begin
    logic [REM_W:0] r;
    r       = '0;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {rem_nxt, num_r[NUM_W-1-i]};
      quo_nxt = {quo_nxt[PERIOD_W-2:0], (r >= DIVISOR)};
      if (r >= DIVISOR) begin
        r = r - DIVISOR;
      end
      rem_nxt = r[REM_W-1:0];
    end
  end

  assign sts.pulse_start = pulse_start;
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RST;
      period_r  <= PERIOD_RST;
      cur_r     <= WAVE_NONE;
      pulses_r  <= '0;
      gap_r     <= 1'b0;
      phase_r   <= '0;
      drive_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (reg_idx_t'(cfg_ch.index))
          REG_AMP_SCALE:  scale_r  <= (cfg_ch.data[SCALE_W-1:0] > SCALE_MAX) ?
                                      SCALE_MAX : cfg_ch.data[SCALE_W-1:0];
          REG_PWM_PERIOD: period_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        cur_r     <= cur_nxt;
        pulses_r  <= pulses_nxt;
        gap_r     <= gap_nxt;
        phase_r   <= phase_nxt;
        drive_r   <= drive_nxt;
        dropped_r <= dropped_nxt;
      end else if (cmd.div_last) begin
        drive_r   <= quo_nxt;
      end
    end
  end

  // Multiply and divide registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r <= NUM_W'(period_r * duty);
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_r << DIV_BITS;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_width_r <= drive_r;
      out_play_r  <= cur_r;
      out_drop_r  <= dropped_r;
    end
  end

  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pulse_width_ns = out_width_r;
  assign out_ch.busy_res       = (out_play_r != WAVE_NONE);
  assign out_ch.playing        = out_play_r;
  assign out_ch.dropped        = out_drop_r;

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_r != '0) |-> (cur_r != WAVE_NONE))
    else $error("pulse width driven while no waveform plays");

  a_busy_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r != WAVE_NONE) |-> (pulses_r != '0))
    else $error("waveform playing with no pulses left");

  a_gap_off: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r |-> (drive_r == '0))
    else $error("output on during a gap");

endmodule

// ===== design/haptic_pulse_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// haptic_pulse_pattern_sequencer: haptic waveform pulse sequencer
// Plays seven fixed waveforms as PWM pulse trains stepped by millisecond
// ticks; reports the current pulse width after every request.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  in_ch     in   valid/ready    cmd (render/tick), waveform
//  out_ch    out  valid/ready    pulse_width_ns, busy_res, playing, dropped
//  cfg_ch    in   valid/ready    index (0 scale, 1 period), data
//
//  A transaction without a pulse start passes through decode and output load.
//  A transaction that starts a pulse passes through decode, the 27x7
//  multiply, the divide-by-100 steps at 8 quotient bits each, output load.
//  rst_n is synchronous; reset restores scale 100 and period 1000000 ns.
//  The next request is taken while a finished result waits in the output
//  register; a stalled output holds the controller before the next load.
//  Configuration writes are taken every cycle.
//
module haptic_pulse_pattern_sequencer import hpps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hpps_in_if.sink    in_ch,
  hpps_out_if.source out_ch,
  hpps_cfg_if.sink   cfg_ch
);

  hpps_cmd_t cmd;
  hpps_sts_t sts;

  // Controller owns the request handshake and the step sequence
  hpps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath holds configuration and waveform state, the arithmetic and the output register
  hpps_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (in_ch.cmd),
    .in_wave (in_ch.waveform),
    .cmd     (cmd),
    .sts     (sts),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule
